// ===== design/cmab_pkg.sv =====
package cmab_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MAX_TAPS_DEF     = 64;

  localparam int CMD_W      = 2;
  localparam int SAMP_W     = 16;
  localparam int TIDX_W     = 6;
  localparam int TAPV_W     = 18;
  localparam int CH_W       = 3;
  localparam int BIDX_W     = 16;
  localparam int VAL_W      = 24;
  localparam int OS_W       = 4;
  localparam int AT_W       = 7;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int COS_W      = 18;
  localparam int HX_W       = TAPV_W + SAMP_W;
  localparam int PROD_W     = HX_W + COS_W;
  localparam int ACC_SHIFT  = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS  = 1'b1;

  localparam logic [OS_W-1:0] OS_RST = 4'd1;
  localparam logic [AT_W-1:0] AT_RST = 7'd64;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

  typedef struct packed {
    logic push;
    logic push_zero;
    logic tap_wr;
    logic div_start;
    logic clear;
    logic mac_start;
    logic chan_clear;
    logic chan_next;
    logic load_out;
    logic point_end;
  } cmab_cmd_t;

  typedef struct packed {
    logic ready_if_push;
    logic tot_match;
    logic div_busy;
    logic mac_busy;
    logic out_free;
    logic chan_last;
  } cmab_sts_t;

  // rounded q1.16 cosine of theta, magnitude rounded half away from zero
  function automatic logic signed [COS_W-1:0] cos_q16(real theta);
    real v;
    real m;
    logic signed [COS_W-1:0] r;
    v = $cos(theta) * 65536.0;
    m = (v < 0.0) ? -v : v;
    r = COS_W'($rtoi(m + 0.5));
    return (v < 0.0) ? -r : r;
  endfunction

endpackage

// ===== design/cmab_ctrl.sv =====
module cmab_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [cmab_pkg::CMD_W-1:0]       in_cmd,
  output logic                             in_stall,
  input  cmab_pkg::cmab_sts_t              sts,
  output cmab_pkg::cmab_cmd_t              cmd
);
  import cmab_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_PT_START, S_MAC, S_OUT} state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_PUSH: begin
              cmd.push = 1'b1;
              if (sts.ready_if_push) state_nxt = S_PT_START;
            end
            CMD_TAP: cmd.tap_wr = 1'b1;
            CMD_DRAIN: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          if (sts.tot_match) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.push_zero = 1'b1;
            state_nxt     = sts.ready_if_push ? S_PT_START : S_IDLE;
          end
        end
      end
      S_PT_START: begin
        cmd.mac_start  = 1'b1;
        cmd.chan_clear = 1'b1;
        state_nxt      = S_MAC;
      end
      S_MAC: begin
        if (!sts.mac_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.chan_last) begin
            cmd.point_end = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.chan_next = 1'b1;
            cmd.mac_start = 1'b1;
            state_nxt     = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/cmab_dp.sv =====
module cmab_dp #(
  parameter int NUM_CHANNELS = cmab_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_TAPS     = cmab_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cmab_pkg::cmab_cmd_t                  cmd,
  output cmab_pkg::cmab_sts_t                  sts,
  input  logic signed [cmab_pkg::SAMP_W-1:0]   in_sample,
  input  logic [cmab_pkg::TIDX_W-1:0]          in_tap_index,
  input  logic signed [cmab_pkg::TAPV_W-1:0]   in_tap_value,
  input  logic                                 cfg_we,
  input  logic [cmab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmab_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cmab_pkg::CH_W-1:0]            out_channel,
  output logic [cmab_pkg::BIDX_W-1:0]          out_band_index,
  output logic signed [cmab_pkg::VAL_W-1:0]    out_value,
  output logic                                 out_run_last,
  output logic                                 out_block_end
);
  import cmab_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int LW    = $clog2(MAX_TAPS + 1);
  localparam int DW    = $clog2(NUM_CHANNELS + 1);
  localparam int CW    = $clog2(NUM_CHANNELS);
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int NUM_W = CNT_W + 1;
  localparam int DCW   = $clog2(NUM_W + 1);
  localparam real STEP = 2.0 * 3.14159265358979323846 / NUM_CHANNELS;

  // cosine rom
  logic signed [COS_W-1:0] cos_tbl [NUM_CHANNELS];
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cos
    assign cos_tbl[g] = cos_q16(g * STEP);
  end

  // configuration
  logic [OS_W-1:0] os_r;
  logic [AT_W-1:0] at_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_r <= OS_RST;
      at_r <= AT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERSAMPLING: os_r <= cfg_wdata[OS_W-1:0];
        REG_ACTIVE_TAPS:  at_r <= cfg_wdata[AT_W-1:0];
        default: ;
      endcase
    end
  end

  int dq;
  logic [DW-1:0] dec;
  logic [LW-1:0] taps_l;

  always_comb begin
    case (os_r)
      4'd0, 4'd1: dq = NUM_CHANNELS;
      4'd2:  dq = NUM_CHANNELS / 2;
      4'd3:  dq = NUM_CHANNELS / 3;
      4'd4:  dq = NUM_CHANNELS / 4;
      4'd5:  dq = NUM_CHANNELS / 5;
      4'd6:  dq = NUM_CHANNELS / 6;
      4'd7:  dq = NUM_CHANNELS / 7;
      4'd8:  dq = NUM_CHANNELS / 8;
      4'd9:  dq = NUM_CHANNELS / 9;
      4'd10: dq = NUM_CHANNELS / 10;
      4'd11: dq = NUM_CHANNELS / 11;
      4'd12: dq = NUM_CHANNELS / 12;
      4'd13: dq = NUM_CHANNELS / 13;
      4'd14: dq = NUM_CHANNELS / 14;
      4'd15: dq = NUM_CHANNELS / 15;
      default: dq = NUM_CHANNELS;
    endcase
    dec = (dq == 0) ? DW'(1) : DW'(dq);
    if (int'(at_r) < NUM_CHANNELS) taps_l = LW'(NUM_CHANNELS);
    else if (int'(at_r) > MAX_TAPS) taps_l = LW'(MAX_TAPS);
    else taps_l = LW'(at_r);
  end

  // counters
  logic [CNT_W-1:0] pos_r, real_r, emit_r;
  logic             last_r;
  logic [AW-1:0]    wp_r;
  logic [CNT_W-1:0] need;
  logic [NUM_W-1:0] quo_r;

  assign need = CNT_W'(emit_r * dec + taps_l);
  assign sts.ready_if_push = (need == CNT_W'(pos_r + 1'b1));
  assign sts.tot_match     = (emit_r == quo_r[CNT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      real_r <= '0;
      emit_r <= '0;
      last_r <= 1'b0;
      wp_r   <= '0;
    end else begin
      if (cmd.push || cmd.push_zero) begin
        pos_r <= pos_r + 1'b1;
        wp_r  <= (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + 1'b1;
      end
      if (cmd.push) begin
        real_r <= real_r + 1'b1;
        last_r <= 1'b0;
      end
      if (cmd.push_zero) last_r <= (CNT_W'(emit_r + 1'b1) == quo_r[CNT_W-1:0]);
      if (cmd.point_end) emit_r <= emit_r + 1'b1;
      if (cmd.clear || (cmd.point_end && last_r)) begin
        pos_r  <= '0;
        real_r <= '0;
        emit_r <= '0;
      end
    end
  end

  // ceil division of real sample count by decimation, one bit a cycle
  logic             div_busy_r;
  logic [DCW-1:0]   div_cnt_r;
  logic [DW-1:0]    rem_r, dvs_r;
  logic [DW:0]      rem_sh;
  logic             div_ge;

  assign rem_sh        = {rem_r, quo_r[NUM_W-1]};
  assign div_ge        = (rem_sh >= {1'b0, dvs_r});
  assign sts.div_busy  = div_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == DCW'(1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r     <= NUM_W'(real_r) + NUM_W'(dec) - 1'b1;
      rem_r     <= '0;
      dvs_r     <= dec;
      div_cnt_r <= DCW'(NUM_W);
    end else if (div_busy_r) begin
      rem_r     <= div_ge ? DW'(rem_sh - {1'b0, dvs_r}) : DW'(rem_sh);
      quo_r     <= {quo_r[NUM_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // sample window and prototype taps
  logic signed [SAMP_W-1:0] win_mem [MAX_TAPS];
  logic signed [TAPV_W-1:0] tap_mem [MAX_TAPS];
  logic signed [SAMP_W-1:0] x_s1;
  logic signed [TAPV_W-1:0] h_s1;
  logic                     issue;
  logic [LW-1:0]            k_r;
  logic [AW-1:0]            raddr_r;

  always_ff @(posedge clk) begin
    if (cmd.push) win_mem[wp_r] <= in_sample;
    else if (cmd.push_zero) win_mem[wp_r] <= '0;
    if (issue) x_s1 <= win_mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_wr && int'(in_tap_index) < MAX_TAPS) tap_mem[AW'(in_tap_index)] <= in_tap_value;
    if (issue) h_s1 <= tap_mem[k_r[AW-1:0]];
  end

  // multiply-accumulate engine
  logic                     run_r, s1_v, s2_v, s3_v;
  logic [CW-1:0]            chan_r, cidx_r;
  logic [CW:0]              cidx_sum;
  logic [AW+1:0]            old_sum;
  logic [AW-1:0]            oldest;
  logic signed [COS_W-1:0]  cos_s1, cos_s2;
  logic signed [HX_W-1:0]   hx_s2;
  logic signed [PROD_W-1:0] p_s3;
  logic signed [ACC_W-1:0]  acc_r;

  assign issue        = run_r && (k_r != taps_l);
  assign sts.mac_busy = run_r;
  assign sts.chan_last = (chan_r == CW'(NUM_CHANNELS - 1));
  assign cidx_sum     = {1'b0, cidx_r} + {1'b0, chan_r};
  assign old_sum      = (AW+2)'(wp_r) + (AW+2)'(MAX_TAPS) - (AW+2)'(taps_l);
  assign oldest       = (old_sum >= (AW+2)'(MAX_TAPS)) ? AW'(old_sum - (AW+2)'(MAX_TAPS))
                                                       : AW'(old_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (cmd.mac_start) run_r <= 1'b1;
      else if (!issue && !s1_v && !s2_v && !s3_v) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chan_clear) chan_r <= '0;
    else if (cmd.chan_next) chan_r <= chan_r + 1'b1;
    if (cmd.mac_start) begin
      k_r     <= '0;
      raddr_r <= oldest;
      cidx_r  <= '0;
      acc_r   <= '0;
    end else begin
      if (issue) begin
        k_r     <= k_r + 1'b1;
        raddr_r <= (raddr_r == AW'(MAX_TAPS - 1)) ? '0 : raddr_r + 1'b1;
        cidx_r  <= (cidx_sum >= (CW+1)'(NUM_CHANNELS)) ? CW'(cidx_sum - (CW+1)'(NUM_CHANNELS))
                                                       : CW'(cidx_sum);
      end
      if (s3_v) acc_r <= acc_r + {{(ACC_W-PROD_W){p_s3[PROD_W-1]}}, p_s3};
    end
    cos_s1 <= cos_tbl[cidx_r];
    cos_s2 <= cos_s1;
    hx_s2  <= h_s1 * x_s1;
    p_s3   <= hx_s2 * cos_s2;
  end

  // result register
  logic signed [ACC_W-ACC_SHIFT-1:0] acc_sh;
  logic signed [63:0]                sh64;
  logic signed [VAL_W-1:0]           sat_val;
  logic                              out_valid_r;

  assign acc_sh = acc_r[ACC_W-1:ACC_SHIFT];
  assign sh64   = 64'(acc_sh);

  always_comb begin
    if (sh64 > 64'(VAL_MAX)) sat_val = VAL_MAX;
    else if (sh64 < 64'(VAL_MIN)) sat_val = VAL_MIN;
    else sat_val = VAL_W'(sh64);
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_channel    <= CH_W'(chan_r);
      out_band_index <= emit_r;
      out_value      <= sat_val;
      out_run_last   <= sts.chan_last;
      out_block_end  <= sts.chan_last && last_r;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transfer");

  a_mac_div: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && div_busy_r))
    else $error("mac and divider active together");

  a_mac_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_start |-> !run_r)
    else $error("mac restarted while running");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.clear) |=> (pos_r == CNT_W'($past(pos_r) + 1'b1)))
    else $error("position count not advanced");

endmodule

// ===== design/cosine_modulated_analysis_bank_top.sv =====
// Cosine-modulated analysis filter bank. Commands push a sample, load a
// prototype tap or drain the block with zeros; each decimation point gives
// NUM_CHANNELS results in channel order. A drain first runs a serial ceil
// divide of the sample count. Each decimation point is computed by the
// single multiply-accumulate pipeline, which walks the L active taps once
// per channel; input commands stall while it runs. Results wait in an output
// register while the next channel is computed.
module cosine_modulated_analysis_bank_top #(
  parameter int NUM_CHANNELS = cmab_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_TAPS     = cmab_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cmab_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [cmab_pkg::SAMP_W-1:0]   in_sample,
  input  logic [cmab_pkg::TIDX_W-1:0]          in_tap_index,
  input  logic signed [cmab_pkg::TAPV_W-1:0]   in_tap_value,
  input  logic                                 cfg_we,
  input  logic [cmab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmab_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cmab_pkg::CH_W-1:0]            out_channel,
  output logic [cmab_pkg::BIDX_W-1:0]          out_band_index,
  output logic signed [cmab_pkg::VAL_W-1:0]    out_value,
  output logic                                 out_run_last,
  output logic                                 out_block_end
);
  import cmab_pkg::*;

  cmab_cmd_t cmd;
  cmab_sts_t sts;

  cmab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmab_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_TAPS     (MAX_TAPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .in_tap_index   (in_tap_index),
    .in_tap_value   (in_tap_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_band_index (out_band_index),
    .out_value      (out_value),
    .out_run_last   (out_run_last),
    .out_block_end  (out_block_end)
  );

endmodule
